[src/p2rf_pkg.sv]
// Shared types and constants for the power-of-two ring FIFO.
`timescale 1ns / 1ps
package p2rf_pkg;

  localparam int MaxDepth = 16;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int CntW     = AddrW + 1;
  localparam int ElemBits = 8;
  localparam int SizeW    = 3;
  localparam int CountW   = 5;
  localparam int OpW      = 3;

  typedef enum logic [OpW-1:0] {
    OpPut     = 3'd0,
    OpGet     = 3'd1,
    OpPeek    = 3'd2,
    OpReadRun = 3'd3,
    OpPeekRun = 3'd4,
    OpFlush   = 3'd5,
    OpDropAll = 3'd6
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]      operation;
    logic [ElemBits-1:0] write_data;
    logic                last_in;
    logic [CountW-1:0]   request_count;
  } in_t;

  typedef struct packed {
    logic [ElemBits-1:0] read_data;
    logic                ok;
    logic                last_out;
    logic [CountW-1:0]   fill_level;
    logic [CountW-1:0]   free_space;
    logic [CountW-1:0]   accepted_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic put;          // store write_data if not full
    logic head_rd;      // get or peek: flag result from head element
    logic status_only;  // result carries status alone
    logic pop;          // advance read counter
    logic run_load;     // start a run at the head; run position takes the next element
    logic run_next;     // advance run position
    logic flush;        // clear both counters
    logic drop;         // read counter takes write counter
    logic out_one;      // emit single result from captured flags
    logic out_run;      // emit run element
    logic out_last;     // mark final result of the transaction
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              empty;
    logic [CountW-1:0] run_len;
  } stat_t;

endpackage

[src/p2rf_ctrl.sv]
// Controller state machine for the power-of-two ring FIFO.
`timescale 1ns / 1ps
module p2rf_ctrl import p2rf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [OpW-1:0] op_i,
  input  stat_t          stat_i,
  output logic           busy,
  output cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SOne  = 3'b010,
    SRun  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] left_q, left_d;
  logic              consume_q, consume_d;
  op_e               op;

  assign op   = op_e'(op_i);
  assign busy = (state_q != SIdle);

  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    consume_d = consume_q;
    cmd_o     = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SOne;
          unique case (op)
            OpPut: cmd_o.put = 1'b1;
            OpGet: begin
              cmd_o.head_rd = 1'b1;
              cmd_o.pop     = !stat_i.empty;
            end
            OpPeek: cmd_o.head_rd = 1'b1;
            OpReadRun, OpPeekRun: begin
              if (stat_i.run_len == '0) begin
                cmd_o.status_only = 1'b1;
              end else begin
                cmd_o.run_load = 1'b1;
                cmd_o.pop      = (op == OpReadRun);
                consume_d      = (op == OpReadRun);
                left_d         = stat_i.run_len;
                state_d        = SRun;
              end
            end
            OpFlush: begin
              cmd_o.flush       = 1'b1;
              cmd_o.status_only = 1'b1;
            end
            OpDropAll: begin
              cmd_o.drop        = 1'b1;
              cmd_o.status_only = 1'b1;
            end
            default: cmd_o.status_only = 1'b1;
          endcase
        end
      end
      SOne: begin
        cmd_o.out_one  = 1'b1;
        cmd_o.out_last = 1'b1;
        state_d        = SIdle;
      end
      SRun: begin
        cmd_o.out_run = 1'b1;
        if (left_q == CountW'(1)) begin
          cmd_o.out_last = 1'b1;
          state_d        = SIdle;
        end else begin
          cmd_o.run_next = 1'b1;
          cmd_o.pop      = consume_q;
          left_d         = left_q - CountW'(1);
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      left_q    <= '0;
      consume_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      left_q    <= left_d;
      consume_q <= consume_d;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_run_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SRun |-> left_q != '0)
    else $error("run active with no elements left");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_last |=> state_q == SIdle)
    else $error("final result not followed by idle");

endmodule

[src/p2rf_dp.sv]
// Datapath for the power-of-two ring FIFO: store, counters and result fields.
`timescale 1ns / 1ps
module p2rf_dp import p2rf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  in_t              in_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output out_t             res_o,
  output logic             res_valid_o
);

  logic [ElemBits-1:0] mem_q [MaxDepth];
  logic [ElemBits-1:0] rdata_q;
  logic [SizeW-1:0]    size_q;
  logic [CntW-1:0]     wr_q, rd_q, pos_q;
  logic [CountW-1:0]   acc_q;
  logic                ok_q, dvalid_q, clear_q;

  logic [SizeW-1:0]    lg;
  logic [AddrW-1:0]    amask, rd_addr, wr_addr;
  logic [CntW-1:0]     cap, fill, free;
  logic                full;

  // Clamp the size register to the supported range.
  always_comb begin
    priority if (size_q == '0) lg = SizeW'(1);
    else if (size_q > SizeW'(AddrW)) lg = SizeW'(AddrW);
    else lg = size_q;
  end

  assign amask   = {AddrW{1'b1}} >> (SizeW'(AddrW) - lg);
  assign cap     = CntW'(1) << lg;
  assign fill    = wr_q - rd_q;
  assign free    = (fill <= cap) ? cap - fill : '0;
  assign full    = (fill > CntW'(amask));
  assign wr_addr = wr_q[AddrW-1:0] & amask;
  assign rd_addr = cmd_i.out_run ? (pos_q[AddrW-1:0] & amask) : (rd_q[AddrW-1:0] & amask);

  assign stat_o.empty   = (fill == '0);
  assign stat_o.run_len = (CountW'(fill) < in_i.request_count) ? CountW'(fill)
                                                               : in_i.request_count;

  always_ff @(posedge clk_i) begin
    if (cmd_i.put && !full) begin
      mem_q[wr_addr] <= in_i.write_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SizeW'(4);
      wr_q     <= '0;
      rd_q     <= '0;
      pos_q    <= '0;
      acc_q    <= '0;
      ok_q     <= 1'b0;
      dvalid_q <= 1'b0;
      clear_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        wr_q   <= '0;
        rd_q   <= '0;
      end else if (cmd_i.flush) begin
        wr_q <= '0;
        rd_q <= '0;
      end else if (cmd_i.drop) begin
        rd_q <= wr_q;
      end else begin
        if (cmd_i.put && !full) wr_q <= wr_q + CntW'(1);
        if (cmd_i.pop) rd_q <= rd_q + CntW'(1);
      end

      if (cmd_i.run_load) pos_q <= rd_q + CntW'(1);
      else if (cmd_i.run_next) pos_q <= pos_q + CntW'(1);

      if (cmd_i.put && !full && acc_q != {CountW{1'b1}}) acc_q <= acc_q + CountW'(1);
      else if (cmd_i.out_one && clear_q) acc_q <= '0;

      if (cmd_i.put) begin
        ok_q     <= !full;
        dvalid_q <= 1'b0;
        clear_q  <= in_i.last_in;
      end else if (cmd_i.head_rd) begin
        ok_q     <= !stat_o.empty;
        dvalid_q <= !stat_o.empty;
        clear_q  <= 1'b0;
      end else if (cmd_i.status_only) begin
        ok_q     <= 1'b0;
        dvalid_q <= 1'b0;
        clear_q  <= 1'b0;
      end
    end
  end

  assign res_valid_o        = cmd_i.out_one || cmd_i.out_run;
  assign res_o.read_data    = (cmd_i.out_run || dvalid_q) ? rdata_q : '0;
  assign res_o.ok           = cmd_i.out_run || ok_q;
  assign res_o.last_out     = cmd_i.out_last;
  assign res_o.fill_level   = CountW'(fill);
  assign res_o.free_space   = CountW'(free);
  assign res_o.accepted_count = acc_q;

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= cap)
    else $error("fill level above capacity");

endmodule

[src/power_of_two_ring_fifo_unit.sv]
// Top level of the power-of-two ring FIFO.
`timescale 1ns / 1ps
//
// Command-driven ring FIFO whose capacity in use is 2^size elements (2..16).
// Input: present a transaction on cmd_i and raise start; it is taken at the
// clock edge where start is high and busy is low. busy stays high until the
// transaction's last result has gone out.
// Output: each result sits on res_o for exactly one cycle with res_valid_o
// high; res_o.last_out marks the final result of the transaction. The
// receiver cannot stall, so results leave at a fixed pace.
// Timing: put, get, peek, flush, drop_all, an empty or zero run, and the
// unused code give one result, and a run of n elements gives n results on
// consecutive cycles, in each case starting in the cycle after acceptance;
// the store's single registered read port, fetching one element per cycle,
// sets this pace. A new transaction is taken only once busy is low.
// Configuration: write the size register through cfg_we_i / cfg_wdata_i while
// idle; any write also clears both counters.
// Reset: counters and the write-run count clear, size returns to 16 entries.
// Store contents are not cleared; only written entries are ever read back.
module power_of_two_ring_fifo_unit import p2rf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  in_t              cmd_i,
  output logic             res_valid_o,
  output out_t             res_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each transaction: decode, step through runs, mark the last result.
  p2rf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (cmd_i.operation),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Hold the store, the free-running counters and the result fields.
  p2rf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
